// File: hdl/bpa_pkg.sv
// Shared types, codes and constants of the buffer pool allocator.
// Depends on nothing; every other file of the block imports it.

package bpa_pkg;

   localparam int MAX_BUFFERS = 32;
   localparam int IDX_W       = 5;
   localparam int CNT_W       = 6;
   localparam int ADDR_W      = 32;
   localparam int SIZE_W      = 21;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 48;

   // request kinds
   localparam logic [1:0] ACT_ALLOC  = 2'd0;
   localparam logic [1:0] ACT_RETURN = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NONE_FREE  = 2'd1;
   localparam logic [1:0] ST_WRONG_POOL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd2;

   // register reset values
   localparam logic [ADDR_W-1:0] BASE_RESET  = 32'd0;
   localparam logic [SIZE_W-1:0] SIZE_RESET  = 21'd512;
   localparam logic [CNT_W-1:0]  LIMIT_RESET = 6'd0;

   typedef struct packed {
      logic start;   // capture a new item and rewind the scan
      logic step;    // examine one buffer and advance
      logic load;    // move the result into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic pool_empty;  // pool holds no buffers
      logic last;        // scan sits on the last buffer of the pool
      logic stop;        // allocate found a free buffer this cycle
   } dp_stat_type;

   // clamp the configured count to the pool's capacity
   function automatic logic [CNT_W-1:0] pool_count(input logic [CNT_W-1:0] limit);
      pool_count = (limit > CNT_W'(MAX_BUFFERS)) ? CNT_W'(MAX_BUFFERS) : limit;
   endfunction

endpackage

// File: hdl/bpa_ctrl.sv
// Controller state machine of the buffer pool allocator.
// Depends on bpa_pkg; drives bpa_dp through command and status structs.

module bpa_ctrl import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_action,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.start = (state_ff == S_IDLE) && req_tvalid;
      cmd.step  = (state_ff == S_SCAN);
      cmd.load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  if ((req_action inside {ACT_ALLOC, ACT_RETURN}) && !stat.pool_empty) begin
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_SCAN: begin
               if (stat.stop || stat.last) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (cmd.load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: hdl/bpa_dp.sv
// Datapath of the buffer pool allocator: registers, in-use marks, scan
// address, free counter and output register. Depends on bpa_pkg.

module bpa_dp import bpa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [1:0]           req_action,
   input  logic [ADDR_W-1:0]    req_address,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   output logic [1:0]           rsp_status,
   output logic [ADDR_W-1:0]    rsp_address,
   output logic [IDX_W-1:0]     rsp_index,
   output logic [CNT_W-1:0]     rsp_free
);

   logic [ADDR_W-1:0]      base_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [CNT_W-1:0]       limit_ff;
   logic [MAX_BUFFERS-1:0] marks_ff;
   logic [CNT_W-1:0]       free_ff;

   logic [1:0]             act_ff;
   logic [ADDR_W-1:0]      ret_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [ADDR_W-1:0]      cur_ff;
   logic                   hit_ff;
   logic [1:0]             res_status_ff;
   logic [ADDR_W-1:0]      res_address_ff;
   logic [IDX_W-1:0]       res_index_ff;

   logic [1:0]             out_status_ff;
   logic [ADDR_W-1:0]      out_address_ff;
   logic [IDX_W-1:0]       out_index_ff;
   logic [CNT_W-1:0]       out_free_ff;

   logic [CNT_W-1:0]       count;
   logic                   free_here;
   logic                   match;

   assign count     = pool_count(limit_ff);
   assign free_here = !marks_ff[idx_ff];
   assign match     = (cur_ff == ret_ff);

   always_comb begin
      stat.pool_empty = (count == '0);
      stat.last       = ((CNT_W'(idx_ff) + CNT_W'(1)) == count);
      stat.stop       = (act_ff == ACT_ALLOC) && free_here;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         size_ff  <= SIZE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE:  base_ff  <= csr_wdata[ADDR_W-1:0];
            CSR_SIZE:  size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_LIMIT: limit_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // in-use marks and free counter; any known register write frees the pool
   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
         free_ff  <= pool_count(LIMIT_RESET);
      end else if (csr_we && (csr_index inside {CSR_BASE, CSR_SIZE, CSR_LIMIT})) begin
         marks_ff <= '0;
         if (csr_index == CSR_LIMIT) begin
            free_ff <= pool_count(csr_wdata[CNT_W-1:0]);
         end else begin
            free_ff <= count;
         end
      end else if (cmd.step) begin
         case (act_ff)
            ACT_ALLOC: begin
               if (free_here) begin
                  marks_ff[idx_ff] <= 1'b1;
                  free_ff          <= free_ff - CNT_W'(1);
               end
            end
            ACT_RETURN: begin
               if (match) begin
                  marks_ff[idx_ff] <= 1'b0;
                  if (!free_here) begin
                     free_ff <= free_ff + CNT_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // scan state and result being built
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         act_ff         <= req_action;
         ret_ff         <= req_address;
         idx_ff         <= '0;
         cur_ff         <= base_ff;
         hit_ff         <= 1'b0;
         res_address_ff <= '0;
         res_index_ff   <= '0;
         case (req_action)
            ACT_ALLOC:  res_status_ff <= ST_NONE_FREE;
            ACT_RETURN: res_status_ff <= ST_WRONG_POOL;
            default:    res_status_ff <= ST_OK;
         endcase
      end else if (cmd.step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         cur_ff <= cur_ff + ADDR_W'(size_ff);
         case (act_ff)
            ACT_ALLOC: begin
               if (free_here) begin
                  res_status_ff  <= ST_OK;
                  res_address_ff <= cur_ff;
                  res_index_ff   <= idx_ff;
               end
            end
            ACT_RETURN: begin
               if (match) begin
                  hit_ff <= 1'b1;
                  if (!hit_ff) begin
                     res_status_ff <= ST_OK;
                     res_index_ff  <= idx_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_status_ff  <= res_status_ff;
         out_address_ff <= res_address_ff;
         out_index_ff   <= res_index_ff;
         out_free_ff    <= free_ff;
      end
   end

   assign rsp_status  = out_status_ff;
   assign rsp_address = out_address_ff;
   assign rsp_index   = out_index_ff;
   assign rsp_free    = out_free_ff;

endmodule

// File: hdl/buffer_pool_allocator.sv
// Top level of the buffer pool allocator: first-fit allocation over a pool
// of equal-sized buffers. Depends on bpa_pkg, bpa_ctrl and bpa_dp.
//
//   channel   direction  signals                        item
//   req       in         req_tvalid/tready/tdata/tuser  one allocate/return/query request
//   rsp       out        rsp_tvalid/tready/tdata/tuser  one result per request
//   csr       in         csr_we/index/wdata             one register write
//
// A query, or any request on an empty pool, skips the scan. An allocate
// scans up to the first free buffer (to the last buffer when none is free);
// a return always scans the whole pool; the single shared address adder
// walks the pool one buffer per cycle.
// Reset clears the registers to their reset values and frees every buffer.
// A result waits in the output register while rsp_tready is low; the next
// request is taken meanwhile and its scan stalls only at its own finish.

module buffer_pool_allocator import bpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] return_address
   input  logic [1:0]            req_tuser,   // [1:0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] granted_address, [36:32] buffer_index,
                                              // [42:37] free_count, [47:43] zero
   output logic [1:0]            rsp_tuser,   // [1:0] status
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   dp_cmd_type        cmd;
   dp_stat_type       stat;
   logic [ADDR_W-1:0] rsp_address;
   logic [IDX_W-1:0]  rsp_index;
   logic [CNT_W-1:0]  rsp_free;

   // sequence the scan: one buffer per cycle while in the scan state
   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // hold registers and marks, walk buffer addresses, build the result
   bpa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_action  (req_tuser),
      .req_address (req_tdata[ADDR_W-1:0]),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_status  (rsp_tuser),
      .rsp_address (rsp_address),
      .rsp_index   (rsp_index),
      .rsp_free    (rsp_free)
   );

   // pack the result fields, lowest field first, zero-fill to whole bytes
   assign rsp_tdata = {(RSP_DATA_W - ADDR_W - IDX_W - CNT_W)'(0), rsp_free, rsp_index, rsp_address};

   // a taken request blocks the next one until its result is loaded
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in progress");

   // a failed allocate means the pool had nothing free, and grants nothing
   a_none_free_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_NONE_FREE) |->
         (rsp_tdata[42:37] == '0) && (rsp_tdata[31:0] == '0) && (rsp_tdata[36:32] == '0))
      else $error("none-free result with nonzero level, address or index");

   // the free level never exceeds the pool capacity
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[42:37] <= CNT_W'(MAX_BUFFERS)))
      else $error("free count above pool capacity");

   // only an allocate result carries a granted address; checked on wrong-pool results
   a_grant_only_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_WRONG_POOL) |-> (rsp_tdata[31:0] == '0))
      else $error("wrong-pool result carries an address");

endmodule

// File: test/buffer_pool_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for buffer_pool_allocator: a directed table, then random
// request phases under changing pool settings. Depends on bpa_pkg and the RTL.

module buffer_pool_allocator_tb;
   import bpa_pkg::*;

   // action code three is unused by the block and behaves as a query
   localparam logic [1:0]           ACT_SPARE   = 2'd3;
   // register index with no register behind it; a write there is dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;
   localparam int                   RANDOM_ITEMS = 1750;
   localparam int                   PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] granted;
      logic [IDX_W-1:0]  index;
      logic [CNT_W-1:0]  free;
   } pool_result_type;

   typedef struct packed {
      logic                 is_write;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [CSR_W-1:0]     wdata;
      logic [1:0]           action;
      logic [ADDR_W-1:0]    addr;
      logic                 typed;    // result below is the expectation
      pool_result_type      result;
   } plan_row_type;

   typedef enum {SINK_ALWAYS, SINK_MOSTLY, SINK_BURSTY} sink_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [31:0] return_address
   logic [1:0]            req_tuser;   // [1:0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [31:0] granted_address, [36:32] buffer_index,
                                       // [42:37] free_count, [47:43] zero
   logic [1:0]            rsp_tuser;   // [1:0] status
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   // shadow of the block: settings and one in-use flag per buffer
   logic [ADDR_W-1:0]      pool_base;
   logic [SIZE_W-1:0]      pool_stride;
   logic [CNT_W-1:0]       pool_limit;
   logic [MAX_BUFFERS-1:0] pool_in_use;

   pool_result_type pending_results[$];   // results owed by the block, oldest first
   pool_result_type next_result;
   pool_result_type seen_result;
   plan_row_type    plan[$];

   // the item on the bus may carry its own typed expectation
   logic            cur_typed;
   pool_result_type cur_expect;

   int failure_count   = 0;
   int results_checked = 0;
   int alloc_count     = 0;
   int return_count    = 0;
   int query_count     = 0;
   int write_count     = 0;
   int random_items    = 0;
   int burst_left      = 0;

   sink_mode_type sink_mode  = SINK_ALWAYS;
   int            sink_left  = 0;
   int            stall_left = 0;

   buffer_pool_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_failure(input string msg);
      if (failure_count < PRINT_LIMIT) begin
         $display("[%0t] FAIL: %s", $realtime, msg);
      end
      failure_count++;
   endtask

   // configured count, clamped to what the pool can hold
   function automatic int pool_size();
      return (pool_limit > CNT_W'(MAX_BUFFERS)) ? MAX_BUFFERS : int'(pool_limit);
   endfunction

   // address of buffer k; wraps at 32 bits like the block's adder
   function automatic logic [ADDR_W-1:0] slot_address(input int k);
      logic [ADDR_W-1:0] offset;
      offset = ADDR_W'(k) * ADDR_W'(pool_stride);
      return pool_base + offset;
   endfunction

   // Work out the result of one request and update the in-use flags.
   function automatic pool_result_type serve_request(input logic [1:0] act,
                                                     input logic [ADDR_W-1:0] addr);
      pool_result_type res;
      int              n;
      int              i;
      logic            hit;
      res  = '0;
      n    = pool_size();
      hit  = 1'b0;
      case (act)
         ACT_ALLOC: begin
            res.status = ST_NONE_FREE;
            // first fit: take the lowest free buffer and stop there
            for (i = 0; i < n && !hit; i++) begin
               if (!pool_in_use[i]) begin
                  pool_in_use[i] = 1'b1;
                  res.status     = ST_OK;
                  res.granted    = slot_address(i);
                  res.index      = IDX_W'(i);
                  hit            = 1'b1;
               end
            end
         end
         ACT_RETURN: begin
            // free every buffer at this address; report the lowest one
            for (i = 0; i < n; i++) begin
               if (slot_address(i) == addr) begin
                  pool_in_use[i] = 1'b0;
                  if (!hit) begin
                     res.index = IDX_W'(i);
                  end
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               res.status = ST_WRONG_POOL;
            end
         end
         default: begin
            // query and the spare code leave the flags alone
         end
      endcase
      for (i = 0; i < n; i++) begin
         if (!pool_in_use[i]) begin
            res.free = res.free + CNT_W'(1);
         end
      end
      return res;
   endfunction

   // Shadow the block at every rising edge: retire results, apply writes,
   // and predict each accepted request.
   always @(posedge clock) begin
      if (reset) begin
         pool_base   = BASE_RESET;
         pool_stride = SIZE_RESET;
         pool_limit  = LIMIT_RESET;
         pool_in_use = '0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_result.status  = rsp_tuser;
            seen_result.granted = rsp_tdata[31:0];
            seen_result.index   = rsp_tdata[36:32];
            seen_result.free    = rsp_tdata[42:37];
            results_checked++;
            if (pending_results.size() == 0) begin
               report_failure($sformatf("result %0d arrived with none outstanding",
                                        results_checked));
            end else begin
               next_result = pending_results.pop_front();
               if (seen_result.status !== next_result.status)
                  report_failure($sformatf("result %0d status: expected %0d, got %0d",
                                 results_checked, next_result.status, seen_result.status));
               if (seen_result.granted !== next_result.granted)
                  report_failure($sformatf("result %0d granted_address: expected %h, got %h",
                                 results_checked, next_result.granted, seen_result.granted));
               if (seen_result.index !== next_result.index)
                  report_failure($sformatf("result %0d buffer_index: expected %0d, got %0d",
                                 results_checked, next_result.index, seen_result.index));
               if (seen_result.free !== next_result.free)
                  report_failure($sformatf("result %0d free_count: expected %0d, got %0d",
                                 results_checked, next_result.free, seen_result.free));
               if (rsp_tdata[47:43] !== 5'd0)
                  report_failure($sformatf("result %0d padding bits not zero: %b",
                                 results_checked, rsp_tdata[47:43]));
            end
         end
         if (csr_we) begin
            write_count++;
            case (csr_index)
               CSR_BASE: begin
                  pool_base   = csr_wdata;
                  pool_in_use = '0;
               end
               CSR_SIZE: begin
                  pool_stride = csr_wdata[SIZE_W-1:0];
                  pool_in_use = '0;
               end
               CSR_LIMIT: begin
                  pool_limit  = csr_wdata[CNT_W-1:0];
                  pool_in_use = '0;
               end
               default: begin
                  // no register here: settings and flags are kept
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ACT_ALLOC:  alloc_count++;
               ACT_RETURN: return_count++;
               default:    query_count++;
            endcase
            next_result = serve_request(req_tuser, req_tdata);
            pending_results.push_back(cur_typed ? cur_expect : next_result);
         end
      end
   end

   // Result side: switch between stall styles every so often, including
   // long stretches that never stall.
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 2));
         sink_left = $urandom_range(20, 200);
      end else begin
         sink_left--;
      end
      case (sink_mode)
         SINK_ALWAYS: rsp_tready <= 1'b1;
         SINK_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 2) == 0) begin
                  stall_left = $urandom_range(1, 10);
               end
            end
         end
      endcase
   end

   // Put one item on the request channel and hold it until taken. Between
   // bursts drop valid for a random gap; inside a burst keep valid high.
   task automatic send_item(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                            input logic typed, input pool_result_type want);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= addr;
      cur_typed  = typed;
      cur_expect = want;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 2'($urandom);
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // Drop valid and wait until every owed result is back, so the block is
   // idle before a register changes.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic plan_row_type chk_row(input logic [1:0] act,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [1:0] st,
                                            input logic [ADDR_W-1:0] granted,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [CNT_W-1:0] free);
      plan_row_type row;
      row                = '0;
      row.action         = act;
      row.addr           = addr;
      row.typed          = 1'b1;
      row.result.status  = st;
      row.result.granted = granted;
      row.result.index   = idx;
      row.result.free    = free;
      return row;
   endfunction

   function automatic plan_row_type req_row(input logic [1:0] act,
                                            input logic [ADDR_W-1:0] addr);
      plan_row_type row;
      row        = '0;
      row.action = act;
      row.addr   = addr;
      return row;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_W-1:0] value);
      plan_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.reg_idx  = idx;
      row.wdata    = value;
      return row;
   endfunction

   // Pick new pool settings for a random phase; extremes come up often.
   task automatic reconfigure();
      logic [CSR_W-1:0] value;
      wait_idle();
      if ($urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 5))
            0:       value = '0;
            1:       value = 32'hFFFF_FFFF - $urandom_range(0, 4096);
            default: value = $urandom;
         endcase
         write_reg(CSR_BASE, value);
      end
      if ($urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = 32'd1;
            2:       value = 32'h001F_FFFF;
            3:       value = 32'h0010_0000;
            4:       value = $urandom;          // upper bits are don't-care
            default: value = $urandom_range(1, 4096);
         endcase
         write_reg(CSR_SIZE, value);
      end
      if ($urandom_range(0, 9) == 0) begin
         write_reg(CSR_SPARE, $urandom);
      end
      case ($urandom_range(0, 9))
         0:       value = '0;
         1:       value = 32'd32;
         2:       value = $urandom_range(33, 63);
         3:       value = $urandom;
         4:       value = 32'd31;
         default: value = $urandom_range(1, 8);
      endcase
      write_reg(CSR_LIMIT, value);
   endtask

   // Mostly allocates and returns of real buffer addresses, with a share of
   // stray addresses, queries and the spare code mixed in.
   task automatic send_random_item();
      logic [1:0]        act;
      logic [ADDR_W-1:0] addr;
      int                n;
      int                pick;
      n    = pool_size();
      pick = $urandom_range(0, 99);
      addr = $urandom;
      if (pick < 45) begin
         act = ACT_ALLOC;
      end else if (pick < 80) begin
         act = ACT_RETURN;
         if (n > 0) addr = slot_address($urandom_range(0, n - 1));
      end else if (pick < 88) begin
         act = ACT_RETURN;
         if (pick < 84) addr = slot_address($urandom_range(n, 40));
      end else if (pick < 96) begin
         act = ACT_QUERY;
      end else begin
         act = ACT_SPARE;
      end
      send_item(act, addr, 1'b0, '0);
      random_items++;
   endtask

   initial begin
      int           phase_len;
      int           waited;
      plan_row_type row;
      logic         last_was_write;

      // hold every input at a known value from the start
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_QUERY;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_BASE;
      csr_wdata  = '0;
      cur_typed  = 1'b0;
      cur_expect = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // after reset the pool is empty: nothing to grant, nothing to return
      plan.push_back(chk_row(ACT_ALLOC,  32'h0, ST_NONE_FREE,  32'h0, 5'd0, 6'd0));
      plan.push_back(chk_row(ACT_RETURN, 32'h0, ST_WRONG_POOL, 32'h0, 5'd0, 6'd0));
      plan.push_back(chk_row(ACT_QUERY,  32'h0, ST_OK,         32'h0, 5'd0, 6'd0));
      // three buffers of 512 bytes from zero: fill, overflow, return
      plan.push_back(reg_row(CSR_LIMIT, 32'd3));
      plan.push_back(chk_row(ACT_ALLOC,  32'h0,   ST_OK,        32'h000, 5'd0, 6'd2));
      plan.push_back(chk_row(ACT_ALLOC,  32'h0,   ST_OK,        32'h200, 5'd1, 6'd1));
      plan.push_back(chk_row(ACT_ALLOC,  32'h0,   ST_OK,        32'h400, 5'd2, 6'd0));
      plan.push_back(chk_row(ACT_ALLOC,  32'h0,   ST_NONE_FREE, 32'h000, 5'd0, 6'd0));
      plan.push_back(chk_row(ACT_RETURN, 32'h200, ST_OK,        32'h000, 5'd1, 6'd1));
      // returning a buffer that is already free still succeeds
      plan.push_back(chk_row(ACT_RETURN, 32'h200, ST_OK,         32'h0, 5'd1, 6'd1));
      plan.push_back(chk_row(ACT_RETURN, 32'h201, ST_WRONG_POOL, 32'h0, 5'd0, 6'd1));
      plan.push_back(chk_row(ACT_SPARE,  32'hFFFF_FFFF, ST_OK,   32'h0, 5'd0, 6'd1));
      // a write to the missing register must keep the in-use flags
      plan.push_back(reg_row(CSR_SPARE, 32'hFFFF_FFFF));
      plan.push_back(chk_row(ACT_QUERY, 32'h0, ST_OK, 32'h0, 5'd0, 6'd1));
      // base near the top, garbage above the size and count fields: the
      // count clamps to the full pool and addresses wrap past zero
      plan.push_back(reg_row(CSR_BASE,  32'hFFFF_FF00));
      plan.push_back(reg_row(CSR_SIZE,  32'hFFE0_0080));
      plan.push_back(reg_row(CSR_LIMIT, 32'hFFFF_FFFF));
      plan.push_back(chk_row(ACT_QUERY, 32'h0, ST_OK, 32'h0, 5'd0, 6'd32));
      plan.push_back(req_row(ACT_ALLOC,  32'h0));
      plan.push_back(req_row(ACT_ALLOC,  32'h0));
      plan.push_back(req_row(ACT_ALLOC,  32'h0));
      plan.push_back(req_row(ACT_RETURN, 32'hFFFF_FF80));
      plan.push_back(req_row(ACT_RETURN, 32'h0000_0E80));   // last buffer, index 31
      // zero size stacks every buffer on the base; one return frees them all
      plan.push_back(reg_row(CSR_SIZE, 32'h0));
      plan.push_back(req_row(ACT_ALLOC,  32'h0));
      plan.push_back(req_row(ACT_ALLOC,  32'h0));
      plan.push_back(req_row(ACT_RETURN, 32'hFFFF_FF00));
      // largest size, single buffer at zero
      plan.push_back(reg_row(CSR_SIZE,  32'h001F_FFFF));
      plan.push_back(reg_row(CSR_BASE,  32'h0));
      plan.push_back(reg_row(CSR_LIMIT, 32'd1));
      plan.push_back(req_row(ACT_ALLOC, 32'h0));
      plan.push_back(chk_row(ACT_ALLOC, 32'h0, ST_NONE_FREE, 32'h0, 5'd0, 6'd0));
      plan.push_back(req_row(ACT_RETURN, 32'h0));

      // walk the table; settle the block before each group of writes
      last_was_write = 1'b0;
      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_write) begin
            if (!last_was_write) wait_idle();
            write_reg(row.reg_idx, row.wdata);
         end else begin
            send_item(row.action, row.addr, row.typed, row.result);
         end
         last_was_write = row.is_write;
      end

      // random phases, each under fresh pool settings
      while (random_items < RANDOM_ITEMS) begin
         reconfigure();
         phase_len = $urandom_range(40, 160);
         repeat (phase_len) begin
            if (random_items < RANDOM_ITEMS) send_random_item();
         end
      end

      // drain, then watch a while longer for stray results
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         report_failure($sformatf("%0d results never arrived", pending_results.size()));
      end
      repeat (40) @(posedge clock);

      $display("Covered %0d allocates, %0d returns and %0d queries under %0d register writes;",
               alloc_count, return_count, query_count, write_count);
      $display("%0d results compared, %0d failures.", results_checked, failure_count);
      if (failure_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Timeout: block stopped making progress");
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
hdl/bpa_pkg.sv
hdl/bpa_ctrl.sv
hdl/bpa_dp.sv
hdl/buffer_pool_allocator.sv
test/buffer_pool_allocator_tb.sv
